// ===== rtl/mkc_pkg.sv =====
// Package for the keyed line cache: sizes, register map and request/result types.
package mkc_pkg;

    localparam int CACHE_SLOTS = 4;
    localparam int SLOT_W      = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int COUNT_W     = $clog2(CACHE_SLOTS + 1);
    localparam int CAP_W       = 32;
    localparam int KEY_W       = CAP_W + 1;
    localparam int OUT_SLOT_W  = 2;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [APB_ADDR_W-1:0] REG_CAPMASK_ADDR = 3'd0;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic             func;
        logic [CAP_W-1:0] cap_mask;
        logic             remote_flag;
    } req_t;

    typedef struct packed {
        logic [OUT_SLOT_W-1:0] slot_index;
        logic                  hit;
        logic                  evicted;
    } rsp_t;

    // One recency position: the key it holds and the slot that owns it.
    typedef struct packed {
        key_t  key;
        slot_t slot;
    } entry_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic shift;
        logic in_use;
    } cell_ctl_t;

endpackage

// ===== rtl/mkc_cell.sv =====
// One recency position of the cache: key/slot storage, key compare and shift from neighbor.
module mkc_cell (
    input  logic              aclk,
    input  mkc_pkg::cell_ctl_t ctl,
    input  mkc_pkg::key_t     lookup_key,
    input  mkc_pkg::entry_t   prev_entry,
    output mkc_pkg::entry_t   entry,
    output logic              match
);
    import mkc_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = ctl.shift ? prev_entry : entry_reg;
    end

    // Payload only: no reset needed.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = ctl.in_use && (entry_reg.key == lookup_key);

endmodule

// ===== rtl/mru_keyed_line_cache_core.sv =====
// Top level of the keyed line cache: recency chain of cells, used count, APB register, result stage.
// A request's result is valid in the cycle after it is accepted (one register stage).
// One request per cycle unless stalled; compare, priority pick and chain shift are combinational.
// Reset: aresetn (synchronous, active low) empties the cache, clears the capability mask register
// and m_valid; cell keys, slot numbers and result payload are not reset, only read once written.
module mru_keyed_line_cache_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mkc_pkg::req_t                     s_data,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output mkc_pkg::rsp_t                     m_data,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mkc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mkc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mkc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mkc_pkg::*;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [CAP_W-1:0] capmask_reg;
    logic [CAP_W-1:0] capmask_next;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_CAPMASK_ADDR);

    always_comb begin
        capmask_next = cfg_wr ? pwdata[CAP_W-1:0] : capmask_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capmask_reg <= '0;
        end else begin
            capmask_reg <= capmask_next;
        end
    end

    // Unknown addresses read as zero.
    assign prdata = (paddr == REG_CAPMASK_ADDR) ? APB_DATA_W'(capmask_reg) : '0;

    // ---------------------------------------------------------------
    // Handshake: accept whenever the result stage is empty or draining
    // ---------------------------------------------------------------
    logic accept;
    logic do_lookup;
    logic do_clear;

    assign s_ready   = !m_valid || m_ready;
    assign accept    = s_valid && s_ready;
    assign do_lookup = accept && (s_data.func == FUNC_LOOKUP);
    assign do_clear  = accept && (s_data.func == FUNC_CLEAR);

    // Key: remote flag on top, masked capabilities below.
    key_t lookup_key;
    assign lookup_key = {s_data.remote_flag, s_data.cap_mask & capmask_reg};

    // ---------------------------------------------------------------
    // Recency chain: cell 0 is most recent, cell CACHE_SLOTS-1 least recent
    // ---------------------------------------------------------------
    logic [COUNT_W-1:0] used_count_reg;
    logic [COUNT_W-1:0] used_count_next;

    entry_t                  cell_entry [CACHE_SLOTS];
    entry_t                  cell_prev  [CACHE_SLOTS];
    cell_ctl_t               cell_ctl   [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0]  cell_match;
    entry_t                  head_entry;

    logic        any_hit;
    slot_t       hit_pos;
    slot_t       promote_pos;
    slot_t       new_slot;
    logic        full;

    assign full = (used_count_reg == COUNT_W'(CACHE_SLOTS));

    // Pick the matching position; used keys are unique, so at most one matches.
    always_comb begin
        any_hit = 1'b0;
        hit_pos = '0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
            if (cell_match[i]) begin
                any_hit = 1'b1;
                hit_pos = SLOT_W'(i);
            end
        end
    end

    // Promote position and the slot that lands at the front.
    always_comb begin
        if (any_hit) begin
            promote_pos = hit_pos;
            new_slot    = cell_entry[hit_pos].slot;
        end else if (!full) begin
            promote_pos = SLOT_W'(used_count_reg);
            new_slot    = SLOT_W'(used_count_reg);
        end else begin
            // evict the least recent slot and reload it
            promote_pos = SLOT_W'(CACHE_SLOTS - 1);
            new_slot    = cell_entry[CACHE_SLOTS-1].slot;
        end
    end

    assign head_entry = '{key: lookup_key, slot: new_slot};

    genvar g;
    generate
        for (g = 0; g < CACHE_SLOTS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_prev[g] = head_entry;
            end else begin : g_link
                assign cell_prev[g] = cell_entry[g-1];
            end

            // Shift every position up to and including the promoted one.
            assign cell_ctl[g].shift  = do_lookup && (SLOT_W'(g) <= promote_pos);
            assign cell_ctl[g].in_use = (used_count_reg > COUNT_W'(g));

            mkc_cell u_cell (
                .aclk       (aclk),
                .ctl        (cell_ctl[g]),
                .lookup_key (lookup_key),
                .prev_entry (cell_prev[g]),
                .entry      (cell_entry[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    // Used count: grow on a miss with room, drop to zero on clear.
    always_comb begin
        used_count_next = used_count_reg;
        if (do_clear) begin
            used_count_next = '0;
        end else if (do_lookup && !any_hit && !full) begin
            used_count_next = used_count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_count_reg <= '0;
        end else begin
            used_count_reg <= used_count_next;
        end
    end

    // ---------------------------------------------------------------
    // Result stage
    // ---------------------------------------------------------------
    logic                  m_valid_reg;
    logic                  m_valid_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    logic [SLOT_W+1:0]     slot_wide;

    // Keep only the low bits of the slot number.
    assign slot_wide = {2'b00, new_slot};

    always_comb begin
        m_valid_next = m_valid_reg;
        rsp_next     = rsp_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            if (do_clear) begin
                rsp_next = '0;
            end else begin
                rsp_next.slot_index = slot_wide[OUT_SLOT_W-1:0];
                rsp_next.hit        = any_hit;
                rsp_next.evicted    = !any_hit && full;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload: hold until taken, no reset.
    always_ff @(posedge aclk) begin
        rsp_reg <= rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= COUNT_W'(CACHE_SLOTS))
        else $error("used count beyond slot count");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        do_clear |=> (used_count_reg == '0))
        else $error("clear did not empty the cache");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.hit && m_data.evicted))
        else $error("result flags both hit and eviction");

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_match))
        else $error("key matched in more than one position");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no result");
`endif

endmodule
